// File: design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Depends on nothing; used by spq_cell and sorted_priority_queue_top.
package spq_pkg;

  localparam int DEPTH    = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 32;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd3;

  // one stored entry
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [HANDLE_W-1:0]     handle;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                    ins;  // insert, store known not full
    logic                    pop;  // shift all toward head, store known not empty
    logic                    rem;  // delete first handle match
    logic signed [KEY_W-1:0] key;
    logic [HANDLE_W-1:0]     handle;
  } cmd_t;

endpackage

// File: design/spq_cell.sv
// One slot of the sorted chain: holds an entry, compares it with the command
// and takes its own, the new, or a neighbor's entry. Depends on spq_pkg.
module spq_cell (
  input  logic           clk,
  input  spq_pkg::cmd_t   cmd,
  input  logic           occupied,
  input  spq_pkg::entry_t left_ent,
  input  spq_pkg::entry_t right_ent,
  input  logic           left_ge,
  output logic           ge,
  input  logic           found_in,
  output logic           found_out,
  input  spq_pkg::entry_t res_in,
  output spq_pkg::entry_t res_out,
  output spq_pkg::entry_t ent
);
  import spq_pkg::*;

  logic   match;
  entry_t ent_next;

  // an empty slot counts as "greater", so the chain of ge stays monotonic
  assign ge        = !occupied || (ent.key >= cmd.key);
  assign match     = occupied && (ent.handle == cmd.handle);
  assign found_out = found_in | match;
  // first match passes its entry down the result chain
  assign res_out   = (match && !found_in) ? ent : res_in;

  // slot update
  always_comb begin
    ent_next = ent;
    if (cmd.ins && ge) begin
      if (left_ge) begin
        ent_next = left_ent;
      end else begin
        ent_next.key    = cmd.key;
        ent_next.handle = cmd.handle;
      end
    end else if (cmd.pop) begin
      ent_next = right_ent;
    end else if (cmd.rem && found_out) begin
      ent_next = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

// File: design/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: command decode, entry count,
// result register and the row of spq_cell slots. Depends on spq_pkg, spq_cell.
//
// Takes one item per clock: busy stays low, and each item's result shows on
// status/out_handle/out_key/count with done high for exactly one cycle, the
// cycle after start. The receiver cannot stall, so results must be taken as
// they come. Entries live in a row of DEPTH cells that compare against the
// command in parallel and shift by one slot in the same cycle; the cycle time
// is set by one key compare plus the first-match chain through the row.
module sorted_priority_queue_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [spq_pkg::KIND_W-1:0]          kind,
  input  logic signed [spq_pkg::KEY_W-1:0]    prio_key,
  input  logic [spq_pkg::HANDLE_W-1:0]        item_handle,
  output logic                                done,
  output logic [spq_pkg::STATUS_W-1:0]        status,
  output logic [spq_pkg::HANDLE_W-1:0]        out_handle,
  output logic signed [spq_pkg::KEY_W-1:0]    out_key,
  output logic [spq_pkg::CNT_W-1:0]           count
);
  import spq_pkg::*;

  logic [CNT_W-1:0]    count_q, count_next;
  logic                accept, is_full, is_empty;
  cmd_t                cmd;
  entry_t              ents [DEPTH];
  entry_t              res_ch [DEPTH+1];
  logic                ge_ch [DEPTH+1];
  logic                fnd_ch [DEPTH+1];
  logic [STATUS_W-1:0] status_next;
  entry_t              res_next;

  // a new item every cycle
  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign is_empty = (count_q == '0);

  // command to the cell row
  always_comb begin
    cmd.ins    = accept && (kind == KIND_INSERT) && !is_full;
    cmd.pop    = accept && (kind == KIND_POP) && !is_empty;
    cmd.rem    = accept && (kind == KIND_REMOVE);
    cmd.key    = prio_key;
    cmd.handle = item_handle;
  end

  // cell row; chain ends are tied off
  assign ge_ch[0]  = 1'b0;
  assign fnd_ch[0] = 1'b0;
  assign res_ch[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e, right_e;
    assign left_e  = (i == 0) ? ents[0] : ents[(i == 0) ? 0 : i-1];
    assign right_e = ents[(i == DEPTH-1) ? i : i+1];
    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occupied  (CNT_W'(i) < count_q),
      .left_ent  (left_e),
      .right_ent (right_e),
      .left_ge   (ge_ch[i]),
      .ge        (ge_ch[i+1]),
      .found_in  (fnd_ch[i]),
      .found_out (fnd_ch[i+1]),
      .res_in    (res_ch[i]),
      .res_out   (res_ch[i+1]),
      .ent       (ents[i])
    );
  end

  // result and count
  always_comb begin
    status_next = ST_OK;
    res_next    = '0;
    count_next  = count_q;
    case (kind)
      KIND_INSERT: begin
        if (is_full) status_next = ST_FULL;
        else         count_next  = count_q + CNT_W'(1);
      end
      KIND_POP, KIND_PEEK: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          res_next = ents[0];
          if (kind == KIND_POP) count_next = count_q - CNT_W'(1);
        end
      end
      KIND_REMOVE: begin
        if (fnd_ch[DEPTH]) begin
          res_next   = res_ch[DEPTH];
          count_next = count_q - CNT_W'(1);
        end else begin
          status_next = ST_NOMATCH;
        end
      end
      KIND_CLEAR: count_next = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_q <= '0;
      done    <= 1'b0;
    end else begin
      done <= accept;
      if (accept) count_q <= count_next;
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= status_next;
      out_handle <= res_next.handle;
      out_key    <= res_next.key;
      count      <= count_next;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_q <= CNT_W'(DEPTH)) else $error("entry count above depth");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done) else $error("accepted item gave no result");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && kind == KIND_CLEAR |=> count == '0 && status == ST_OK && count_q == '0)
    else $error("clear left entries");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    accept && kind == KIND_INSERT && is_full |=> status == ST_FULL && $stable(count_q))
    else $error("insert into full store not dropped");

  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> out_handle == '0 && out_key == '0)
    else $error("payload not zero on failed item");

endmodule
